### rtl/core/wrxr_pkg.sv
// Shared types, constants and helpers for the word ring shift/xor generator.
// No dependencies; imported by every module in rtl/core.
package wrxr_pkg;

   localparam int RING_WORDS = 32;
   localparam int IDX_W      = $clog2(RING_WORDS);
   localparam int CNT_W      = IDX_W;
   localparam int WORD_W     = 32;
   localparam int SHIFT_W    = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // tap sum (tap + 1) reaches 32 and must fit next to a full ring index
   localparam int TAP_SUM_W  = ((IDX_W > 6) ? IDX_W : 6) + 1;
   localparam int TAP_STEPS  = 32 / RING_WORDS;

   localparam logic [WORD_W-1:0] SEED_MULT = 32'd1812433253;
   localparam int                BACK_TAP  = 4;

   localparam logic [SHIFT_W-1:0] TAP_OFFSET_RST    = 5'd11;
   localparam logic [SHIFT_W-1:0] SHIFT_LEFT_A_RST  = 5'd5;
   localparam logic [SHIFT_W-1:0] SHIFT_LEFT_B_RST  = 5'd1;
   localparam logic [SHIFT_W-1:0] SHIFT_RIGHT_C_RST = 5'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TAP_OFFSET    = 3'd0,
      CSR_SHIFT_LEFT_A  = 3'd1,
      CSR_SHIFT_LEFT_B  = 3'd2,
      CSR_SHIFT_RIGHT_C = 3'd3
   } csr_index_type;

   typedef enum logic [0:0] {
      FUNC_SEED     = 1'b0,
      FUNC_GENERATE = 1'b1
   } func_type;

   typedef enum logic [0:0] {
      SEED_IDLE = 1'b0,
      SEED_RUN  = 1'b1
   } seed_state_type;

   // seeder -> ring control
   typedef struct packed {
      logic              shift;
      logic              done;
      logic [WORD_W-1:0] word;
   } seed_ctl_type;

   // ring position of tap b after the ring advances one step
   function automatic logic [IDX_W-1:0] tap_position(input logic [SHIFT_W-1:0] tap);
      logic [TAP_SUM_W-1:0] sum;
      sum = TAP_SUM_W'(tap) + TAP_SUM_W'(1);
      for (int s = 0; s < TAP_STEPS; s++) begin
         if (sum >= TAP_SUM_W'(RING_WORDS)) begin
            sum = sum - TAP_SUM_W'(RING_WORDS);
         end
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

### rtl/core/wrxr_cell.sv
// One ring cell: a 32-bit word that takes its neighbor's word on each shift,
// or an alternate word at the ring ends. Depends on wrxr_pkg.
module wrxr_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic                       alt_sel,
   input  logic [wrxr_pkg::WORD_W-1:0] neighbor_word,
   input  logic [wrxr_pkg::WORD_W-1:0] alt_word,
   output logic [wrxr_pkg::WORD_W-1:0] word_out
);
   import wrxr_pkg::*;

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (load) begin
         word_in = alt_sel ? alt_word : neighbor_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
      end else begin
         word_ff <= word_in;
      end
   end

   assign word_out = word_ff;

endmodule

### rtl/core/wrxr_seeder.sv
// Seed sequencer: walks the ring once, producing one seed word per cycle
// into the ring tail. Depends on wrxr_pkg.
module wrxr_seeder (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [wrxr_pkg::WORD_W-1:0] seed_word,
   output logic                        busy,
   output wrxr_pkg::seed_ctl_type      seed_ctl
);
   import wrxr_pkg::*;

   seed_state_type    state_ff, state_in;
   logic [WORD_W-1:0] seed_ff, seed_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [WORD_W-1:0] mixed;

   assign mixed = seed_ff ^ (seed_ff >> 30);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEED_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      seed_ff <= seed_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      seed_in       = seed_ff;
      seed_ctl      = '0;
      seed_ctl.word = seed_ff;
      busy          = 1'b0;
      unique case (state_ff)
         SEED_IDLE: begin
            if (start) begin
               seed_in  = seed_word;
               count_in = '0;
               state_in = SEED_RUN;
            end
         end
         SEED_RUN: begin
            busy           = 1'b1;
            seed_ctl.shift = 1'b1;
            seed_in        = (mixed * SEED_MULT) + WORD_W'(count_ff);
            count_in       = count_ff + CNT_W'(1);
            if (count_ff == CNT_W'(RING_WORDS - 1)) begin
               seed_ctl.done = 1'b1;
               count_in      = '0;
               state_in      = SEED_IDLE;
            end
         end
         default: begin
            state_in = SEED_IDLE;
         end
      endcase
   end

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      seed_ctl.done |=> (state_ff == SEED_IDLE))
      else $error("seeder still running after done");

endmodule

### rtl/core/word_ring_shift_xor_rng.sv
// Top level of the word ring shift/xor generator: ring of cells, seeder,
// tap muxing and the result register. Depends on wrxr_pkg, wrxr_cell, wrxr_seeder.
//
//   channel | direction | handshake              | payload
//   req_    | in        | req_valid / req_stall  | req_func, req_seed_word
//   rsp_    | out       | rsp_valid / rsp_stall  | rsp_random_word, rsp_seeded_ack
//   csr_    | in        | csr_valid / csr_ready  | csr_index, csr_data
//
// Generate: one request per cycle while req_stall is low, result in the next cycle;
// the ring rotates one cell per request, so the current word always sits in cell 0.
// Seed: a load, then one ring shift per word through the seed multiplier;
// req_stall is high while the seeder runs.
// req_stall is also high while a result is held by rsp_stall.
// Reset clears the ring to zero and restores the register defaults.
module word_ring_shift_xor_rng (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_func,
   input  logic [wrxr_pkg::WORD_W-1:0]     req_seed_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [wrxr_pkg::WORD_W-1:0]     rsp_random_word,
   output logic                            rsp_seeded_ack,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [wrxr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wrxr_pkg::CSR_DATA_W-1:0] csr_data
);
   import wrxr_pkg::*;

   logic [SHIFT_W-1:0] tap_offset_ff, tap_offset_in;
   logic [SHIFT_W-1:0] shl_a_ff, shl_a_in;
   logic [SHIFT_W-1:0] shl_b_ff, shl_b_in;
   logic [SHIFT_W-1:0] shr_c_ff, shr_c_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_word_ff, rsp_word_in;
   logic              rsp_ack_ff, rsp_ack_in;

   logic [WORD_W-1:0] cell_word [RING_WORDS];
   logic              ring_shift;
   logic              seed_busy;
   seed_ctl_type      seed_ctl;

   logic              req_fire;
   logic              gen_fire;
   logic              seed_start;
   logic [WORD_W-1:0] word_a, word_b, word_c, gen_word;

   // ---- configuration registers ----
   assign csr_ready = 1'b1;

   always_comb begin
      tap_offset_in = tap_offset_ff;
      shl_a_in      = shl_a_ff;
      shl_b_in      = shl_b_ff;
      shr_c_in      = shr_c_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TAP_OFFSET:    tap_offset_in = csr_data[SHIFT_W-1:0];
            CSR_SHIFT_LEFT_A:  shl_a_in      = csr_data[SHIFT_W-1:0];
            CSR_SHIFT_LEFT_B:  shl_b_in      = csr_data[SHIFT_W-1:0];
            CSR_SHIFT_RIGHT_C: shr_c_in      = csr_data[SHIFT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_offset_ff <= TAP_OFFSET_RST;
         shl_a_ff      <= SHIFT_LEFT_A_RST;
         shl_b_ff      <= SHIFT_LEFT_B_RST;
         shr_c_ff      <= SHIFT_RIGHT_C_RST;
      end else begin
         tap_offset_ff <= tap_offset_in;
         shl_a_ff      <= shl_a_in;
         shl_b_ff      <= shl_b_in;
         shr_c_ff      <= shr_c_in;
      end
   end

   // ---- request intake ----
   assign req_stall  = seed_busy || (rsp_valid_ff && rsp_stall);
   assign req_fire   = req_valid && !req_stall;
   assign gen_fire   = req_fire && (req_func == FUNC_GENERATE);
   assign seed_start = req_fire && (req_func == FUNC_SEED);
   assign ring_shift = gen_fire || seed_ctl.shift;

   // ---- taps, seen before the ring advances ----
   assign word_a   = cell_word[1];
   assign word_b   = cell_word[tap_position(tap_offset_ff)];
   assign word_c   = cell_word[RING_WORDS + 1 - BACK_TAP];
   assign gen_word = (word_a << shl_a_ff) ^ word_a
                   ^ (word_b << shl_b_ff) ^ word_b
                   ^ (word_c >> shr_c_ff) ^ word_c;

   // ---- ring of cells, rotating toward cell 0 ----
   for (genvar k = 0; k < RING_WORDS; k++) begin : g_cell
      logic [WORD_W-1:0] alt_word;
      logic              alt_sel;

      if (k == 0) begin : g_head
         assign alt_word = gen_word;
         assign alt_sel  = gen_fire;
      end else if (k == RING_WORDS - 1) begin : g_tail
         assign alt_word = seed_ctl.word;
         assign alt_sel  = seed_ctl.shift;
      end else begin : g_mid
         assign alt_word = cell_word[k + 1];
         assign alt_sel  = 1'b0;
      end

      wrxr_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .load          (ring_shift),
         .alt_sel       (alt_sel),
         .neighbor_word (cell_word[(k + 1) % RING_WORDS]),
         .alt_word      (alt_word),
         .word_out      (cell_word[k])
      );
   end

   wrxr_seeder u_seeder (
      .clock     (clock),
      .reset     (reset),
      .start     (seed_start),
      .seed_word (req_seed_word),
      .busy      (seed_busy),
      .seed_ctl  (seed_ctl)
   );

   // ---- result register ----
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      rsp_ack_in   = rsp_ack_ff;
      priority if (gen_fire) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = gen_word;
         rsp_ack_in   = 1'b0;
      end else if (seed_ctl.done) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = '0;
         rsp_ack_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      rsp_ack_ff  <= rsp_ack_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_random_word = rsp_word_ff;
   assign rsp_seeded_ack  = rsp_ack_ff;

   a_no_gen_while_seeding: assert property (@(posedge clock) disable iff (reset)
      seed_busy |-> !gen_fire)
      else $error("generate accepted while ring is seeding");

   a_seed_done_result: assert property (@(posedge clock) disable iff (reset)
      seed_ctl.done |=> (rsp_valid && rsp_seeded_ack && (rsp_random_word == '0)))
      else $error("seed completion did not post an acknowledge");

   a_gen_result: assert property (@(posedge clock) disable iff (reset)
      gen_fire |=> (rsp_valid && !rsp_seeded_ack && (rsp_random_word == cell_word[0])))
      else $error("generated word missing from result or ring head");

   a_done_slot_free: assert property (@(posedge clock) disable iff (reset)
      seed_ctl.done |-> !(rsp_valid_ff && rsp_stall))
      else $error("seed completion found the result register occupied");

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for word_ring_shift_xor_rng: seeds, generates and register writes.
// Predicts every response from its own copy of the ring; depends on wrxr_pkg and the RTL.
module tb_top;
   import wrxr_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1680;
   localparam int MAX_WAIT     = 11;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              ack;
   } rng_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_func;
   logic [WORD_W-1:0]     req_seed_word;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [WORD_W-1:0]     rsp_random_word;
   logic                  rsp_seeded_ack;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // predicted generator state
   logic [WORD_W-1:0]  ring_exp [RING_WORDS];
   int                 ring_pos;
   logic [SHIFT_W-1:0] tap_reg;
   logic [SHIFT_W-1:0] sla_reg;
   logic [SHIFT_W-1:0] slb_reg;
   logic [SHIFT_W-1:0] src_reg;

   rng_result_type pending_results [$];
   int             error_count = 0;
   int             items_sent  = 0;
   int             cycle_count = 0;
   int             hold_left   = 0;
   bit             idle_on     = 1'b1;

   word_ring_shift_xor_rng DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_seed_word   (req_seed_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_random_word (rsp_random_word),
      .rsp_seeded_ack  (rsp_seeded_ack),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic void seed_ring(input logic [WORD_W-1:0] seed);
      logic [WORD_W-1:0] s;
      s = seed;
      for (int i = 0; i < RING_WORDS; i++) begin
         ring_exp[i] = s;
         s = SEED_MULT * (s ^ (s >> 30)) + WORD_W'(i);
      end
      ring_pos = 0;
   endfunction

   function automatic logic [WORD_W-1:0] next_word();
      logic [WORD_W-1:0] a, b, c, v;
      ring_pos = (ring_pos + 1) % RING_WORDS;
      a = ring_exp[ring_pos];
      b = ring_exp[(ring_pos + int'(tap_reg)) % RING_WORDS];
      c = ring_exp[(ring_pos + RING_WORDS - BACK_TAP) % RING_WORDS];
      v = (a << sla_reg) ^ a ^ (b << slb_reg) ^ b ^ (c >> src_reg) ^ c;
      ring_exp[ring_pos] = v;
      return v;
   endfunction

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_TAP_OFFSET:    tap_reg = data[SHIFT_W-1:0];
         CSR_SHIFT_LEFT_A:  sla_reg = data[SHIFT_W-1:0];
         CSR_SHIFT_LEFT_B:  slb_reg = data[SHIFT_W-1:0];
         CSR_SHIFT_RIGHT_C: src_reg = data[SHIFT_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] random_seed();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [SHIFT_W-1:0] random_shift();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return SHIFT_W'($urandom_range(0, 31));
      endcase
   endfunction

   // response side: check each accepted response, then hold off a random while if idle_on is set
   always @(posedge clock) begin
      rng_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $display("%0t: response with nothing pending: word %h ack %b", $time,
                        rsp_random_word, rsp_seeded_ack);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_random_word !== want.word) begin
                  $display("%0t: random_word expected %h actual %h", $time,
                           want.word, rsp_random_word);
                  error_count++;
               end
               if (rsp_seeded_ack !== want.ack) begin
                  $display("%0t: seeded_ack expected %b actual %b", $time,
                           want.ack, rsp_seeded_ack);
                  error_count++;
               end
            end
            hold_left = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
         end else if (hold_left > 0) begin
            hold_left--;
         end
         rsp_stall <= (hold_left != 0);
      end
   end

   task automatic send_request(input func_type f, input logic [WORD_W-1:0] seed);
      int             gap;
      rng_result_type r;
      gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= f;
      req_seed_word <= seed;
      do @(posedge clock); while (req_stall);
      if (f == FUNC_SEED) begin
         seed_ring(seed);
         r.word = '0;
         r.ack  = 1'b1;
      end else begin
         r.word = next_word();
         r.ack  = 1'b0;
      end
      pending_results.push_back(r);
      items_sent++;
   endtask

   // drop valid and drain all pending responses
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // program all four registers plus one unmapped index; random upper data bits
   task automatic write_settings(input logic [SHIFT_W-1:0] tap, sla, slb, src);
      logic [CSR_IDX_W-1:0]  idx_list [5];
      logic [SHIFT_W-1:0]    val_list [5];
      logic [CSR_DATA_W-1:0] data;
      idx_list = '{CSR_TAP_OFFSET, CSR_SHIFT_LEFT_A, CSR_SHIFT_LEFT_B, CSR_SHIFT_RIGHT_C,
                   CSR_IDX_W'($urandom_range(int'(CSR_SHIFT_RIGHT_C) + 1,
                                             2**CSR_IDX_W - 1))};
      val_list = '{tap, sla, slb, src, random_shift()};
      for (int k = 0; k < 5; k++) begin
         data = $urandom();
         data[SHIFT_W-1:0] = val_list[k];
         csr_valid <= 1'b1;
         csr_index <= idx_list[k];
         csr_data  <= data;
         do @(posedge clock); while (!csr_ready);
         apply_register(idx_list[k], data);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic test_unseeded_output();
      for (int i = 0; i < 3; i++) send_request(FUNC_GENERATE, $urandom());
      wait_idle();
   endtask

   task automatic test_seed_extremes();
      send_request(FUNC_SEED, '0);
      send_request(FUNC_GENERATE, '1);
      send_request(FUNC_SEED, '1);
      send_request(FUNC_GENERATE, '0);
      send_request(FUNC_GENERATE, $urandom());
      send_request(FUNC_SEED, WORD_W'(1));
      send_request(FUNC_GENERATE, $urandom());
      wait_idle();
   endtask

   // tap at both ends of its range and outside it, shifts at both extremes
   task automatic test_register_extremes();
      write_settings(SHIFT_W'(27), '1, '1, '1);
      send_request(FUNC_SEED, $urandom());
      send_request(FUNC_GENERATE, $urandom());
      send_request(FUNC_GENERATE, $urandom());
      wait_idle();
      write_settings('0, '0, '0, '0);
      send_request(FUNC_SEED, $urandom());
      send_request(FUNC_GENERATE, $urandom());
      wait_idle();
      write_settings('1, random_shift(), random_shift(), random_shift());
      send_request(FUNC_SEED, $urandom());
      send_request(FUNC_GENERATE, $urandom());
      send_request(FUNC_GENERATE, $urandom());
      wait_idle();
      write_settings(SHIFT_W'(3), SHIFT_W'(4), '0, '1);
      send_request(FUNC_GENERATE, $urandom());
      send_request(FUNC_GENERATE, $urandom());
      wait_idle();
   endtask

   // seeded streams of generates with the odd reseed, under random settings
   task automatic test_random_streams();
      int n;
      while (items_sent < RANDOM_ITEMS) begin
         n = $urandom_range(40, 160);
         idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) == 0) begin
            write_settings(TAP_OFFSET_RST, SHIFT_LEFT_A_RST, SHIFT_LEFT_B_RST,
                           SHIFT_RIGHT_C_RST);
         end else begin
            write_settings(($urandom_range(0, 3) == 0) ? SHIFT_W'($urandom_range(0, 31))
                                                       : SHIFT_W'($urandom_range(4, 27)),
                           random_shift(), random_shift(), random_shift());
         end
         send_request(FUNC_SEED, random_seed());
         for (int i = 1; i < n; i++) begin
            send_request(($urandom_range(0, 39) == 0) ? FUNC_SEED : FUNC_GENERATE,
                         random_seed());
         end
         wait_idle();
      end
   endtask

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_func      <= FUNC_GENERATE;
      req_seed_word <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= CSR_TAP_OFFSET;
      csr_data      <= '0;
      for (int i = 0; i < RING_WORDS; i++) ring_exp[i] = '0;
      ring_pos = 0;
      tap_reg  = TAP_OFFSET_RST;
      sla_reg  = SHIFT_LEFT_A_RST;
      slb_reg  = SHIFT_LEFT_B_RST;
      src_reg  = SHIFT_RIGHT_C_RST;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_unseeded_output();
      test_seed_extremes();
      test_register_extremes();
      test_random_streams();

      wait_idle();
      repeat (RING_WORDS + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
